// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OVE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define OVE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: hw/rtl/ove_pkg.sv
package ove_pkg;

  // Range boundaries of the encoding.
  localparam logic [63:0] OneByteMax     = 64'd240;
  localparam logic [63:0] TwoByteMax     = 64'd2287;
  localparam logic [63:0] ThreeByteMax   = 64'd67823;
  localparam logic [11:0] TwoByteBase    = 12'd240;
  localparam logic [16:0] ThreeByteBase  = 17'd2288;
  localparam logic [7:0]  TwoHeadBase    = 8'd241;
  localparam logic [7:0]  ThreeHead      = 8'hF9;
  localparam logic [7:0]  WideHeadBase   = 8'hFA;

  // Longest encoded body (head plus eight bytes) and longest run with prefix.
  localparam int unsigned EncMax = 9;
  localparam int unsigned RunMax = 10;

  // Size class of a value.
  typedef enum logic [1:0] {
    CLS_ONE,
    CLS_TWO,
    CLS_THREE,
    CLS_WIDE
  } cls_e;

  // Request after classification.
  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  kind;
    logic        invert;
    cls_e        cls;
    logic [2:0]  extra;
  } cls_t;

  // Encoded body before masking and prefixing.
  typedef struct packed {
    logic [EncMax-1:0][7:0] enc;
    logic [3:0]             enc_len;
    logic [7:0]             kind;
    logic                   invert;
  } enc_t;

  // Complete byte run, first byte at index 0.
  typedef struct packed {
    logic [RunMax-1:0][7:0] run;
    logic [3:0]             run_len;
  } run_t;

endpackage

// File: hw/rtl/ove_classify.sv
module ove_classify (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [63:0]   value_i,
  input  logic [7:0]    kind_prefix_i,
  input  logic          invert_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ove_pkg::cls_t data_o
);

  logic          valid_q;
  ove_pkg::cls_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  // Sort the value into its size class and count the bytes beyond three.
  always_comb begin
    data_d.value  = value_i;
    data_d.kind   = kind_prefix_i;
    data_d.invert = invert_i;
    if (value_i <= ove_pkg::OneByteMax) begin
      data_d.cls = ove_pkg::CLS_ONE;
    end else if (value_i <= ove_pkg::TwoByteMax) begin
      data_d.cls = ove_pkg::CLS_TWO;
    end else if (value_i <= ove_pkg::ThreeByteMax) begin
      data_d.cls = ove_pkg::CLS_THREE;
    end else begin
      data_d.cls = ove_pkg::CLS_WIDE;
    end
    if (value_i[63:56] != 8'h00) begin
      data_d.extra = 3'd5;
    end else if (value_i[55:48] != 8'h00) begin
      data_d.extra = 3'd4;
    end else if (value_i[47:40] != 8'h00) begin
      data_d.extra = 3'd3;
    end else if (value_i[39:32] != 8'h00) begin
      data_d.extra = 3'd2;
    end else if (value_i[31:24] != 8'h00) begin
      data_d.extra = 3'd1;
    end else begin
      data_d.extra = 3'd0;
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ove_body.sv
module ove_body (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ove_pkg::cls_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ove_pkg::enc_t data_o
);

  logic          valid_q;
  ove_pkg::enc_t data_q, data_d;
  logic [11:0]   d2;
  logic [16:0]   d3;
  logic [5:0]    shamt;
  logic [63:0]   aligned;

  assign ready_o = !valid_q || ready_i;

  // Offsets of the two- and three-byte forms, and the wide value left-aligned.
  assign d2      = data_i.value[11:0] - ove_pkg::TwoByteBase;
  assign d3      = data_i.value[16:0] - ove_pkg::ThreeByteBase;
  assign shamt   = {3'd5 - data_i.extra, 3'b000};
  assign aligned = data_i.value << shamt;

  // Build the head and the body bytes in emission order.
  always_comb begin
    data_d.enc     = '0;
    data_d.enc_len = 4'd1;
    data_d.kind    = data_i.kind;
    data_d.invert  = data_i.invert;
    case (data_i.cls)
      ove_pkg::CLS_ONE: begin
        data_d.enc[0]  = data_i.value[7:0];
        data_d.enc_len = 4'd1;
      end
      ove_pkg::CLS_TWO: begin
        data_d.enc[0]  = ove_pkg::TwoHeadBase + {4'h0, d2[11:8]};
        data_d.enc[1]  = d2[7:0];
        data_d.enc_len = 4'd2;
      end
      ove_pkg::CLS_THREE: begin
        data_d.enc[0]  = ove_pkg::ThreeHead;
        data_d.enc[1]  = d3[15:8];
        data_d.enc[2]  = d3[7:0];
        data_d.enc_len = 4'd3;
      end
      ove_pkg::CLS_WIDE: begin
        data_d.enc[0] = ove_pkg::WideHeadBase + {5'd0, data_i.extra};
        for (int i = 0; i < 8; i++) begin
          data_d.enc[i+1] = aligned[63-8*i -: 8];
        end
        data_d.enc_len = 4'd4 + {1'b0, data_i.extra};
      end
      default: begin
        data_d.enc_len = 4'd1;
      end
    endcase
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ove_frame.sv
module ove_frame (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ove_pkg::enc_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ove_pkg::run_t data_o
);

  logic                            valid_q;
  ove_pkg::run_t                   data_q, data_d;
  logic [ove_pkg::EncMax-1:0][7:0] masked;

  assign ready_o = !valid_q || ready_i;

  // Invert the body for negative magnitudes; the prefix stays as given.
  always_comb begin
    for (int i = 0; i < ove_pkg::EncMax; i++) begin
      masked[i] = data_i.enc[i] ^ {8{data_i.invert}};
    end
  end

  // Put the prefix in front when it is non-zero.
  always_comb begin
    data_d.run = '0;
    if (data_i.kind != 8'h00) begin
      data_d.run[0] = data_i.kind;
      for (int i = 0; i < ove_pkg::EncMax; i++) begin
        data_d.run[i+1] = masked[i];
      end
      data_d.run_len = data_i.enc_len + 4'd1;
    end else begin
      for (int i = 0; i < ove_pkg::EncMax; i++) begin
        data_d.run[i] = masked[i];
      end
      data_d.run_len = data_i.enc_len;
    end
  end

  // Valid bit of the stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ove_serial.sv
module ove_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ove_pkg::run_t data_i,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);

  logic                            valid_q;
  logic [3:0]                      rem_q;
  logic [ove_pkg::RunMax-1:0][7:0] buf_q;
  logic                            on_last;

  assign on_last = (rem_q == 4'd1);
  // A new run may load while the final byte of the current one goes out.
  assign ready_o = !valid_q || on_last;

  // Byte counter and valid flag of the run being sent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= 4'd0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      rem_q   <= valid_i ? data_i.run_len : 4'd0;
    end else begin
      rem_q <= rem_q - 4'd1;
    end
  end

  // Shift line holding the bytes still to send, next byte at index 0.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      buf_q <= data_i.run;
    end else begin
      buf_q <= buf_q >> 8;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = buf_q[0];
  assign last_o      = valid_q && on_last;

endmodule

// File: hw/rtl/ordered_varint_encoder.sv
// Path: a request taken into the classify stage moves through the body and frame stages
// into the serialiser, and waits in a stage while an earlier run is still being sent.
// Throughput: one output byte per cycle; a run of 1 to 10 bytes holds the serialiser until
// its final byte goes out, and the next run loads while that byte is sent.
// The receiver cannot stall; only the serialiser holds requests back through busy.
// Reset: rst_ni clears all stage valid bits at once; no byte is sent until a new request.
module ordered_varint_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_i,
  input  logic [7:0]  kind_prefix_i,
  input  logic        invert_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic          s1_ready, s1_valid;
  logic          s2_ready, s2_valid;
  logic          s3_ready, s3_valid;
  logic          ser_ready;
  ove_pkg::cls_t s1_data;
  ove_pkg::enc_t s2_data;
  ove_pkg::run_t s3_data;

  // A request waits while the first stage cannot move on.
  assign busy = !s1_ready;

  // Stage one: size class and extra byte count.
  ove_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start),
    .ready_o       (s1_ready),
    .value_i       (value_i),
    .kind_prefix_i (kind_prefix_i),
    .invert_i      (invert_i),
    .valid_o       (s1_valid),
    .ready_i       (s2_ready),
    .data_o        (s1_data)
  );

  // Stage two: head and body bytes.
  ove_body u_body (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  // Stage three: inversion and prefix.
  ove_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (ser_ready),
    .data_o  (s3_data)
  );

  // Serialiser: one byte a cycle onto the result ports.
  ove_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s3_valid),
    .ready_o     (ser_ready),
    .data_i      (s3_data),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// File: hw/rtl/ove_checker.sv
`include "assert_macros.svh"

module ove_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        out_valid_o,
  input logic        last_o
);

  // A run that has not reached its final byte carries on in the next cycle.
  `OVE_ASSERT_NEXT(a_run_continues, out_valid_o && !last_o, out_valid_o)

  // The final-byte flag never stands without a byte.
  `OVE_ASSERT_NOW(a_last_needs_valid, last_o, out_valid_o)

  // Requests are held off only while a run is part way out.
  `OVE_ASSERT_NOW(a_busy_while_sending, busy, out_valid_o && !last_o)

  // A request refused for lack of room still finds the serialiser sending in the next cycle.
  `OVE_ASSERT_NEXT(a_busy_then_bytes, start && busy, out_valid_o)

endmodule

bind ordered_varint_encoder ove_checker u_ove_checker (.*);
